// ===== rtl/bounded_double_ended_queue_top_defines.svh =====
// ----------------------------------------------------------------------------
// bounded double-ended queue assertion macros
// shared assertion forms, clocked on clk_i and quiet while rst_ni is low
// ----------------------------------------------------------------------------
`ifndef BOUNDED_DOUBLE_ENDED_QUEUE_TOP_DEFINES_SVH
`define BOUNDED_DOUBLE_ENDED_QUEUE_TOP_DEFINES_SVH

// property must hold at every edge out of reset
`define BDQ_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// condition must never be seen out of reset
`define BDQ_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

// ===== rtl/bdq_pkg.sv =====
// ----------------------------------------------------------------------------
// bdq_pkg
// types and constants of the bounded double-ended queue
// ----------------------------------------------------------------------------
`default_nettype none

package bdq_pkg;

  localparam int unsigned KIND_W         = 3;
  localparam int unsigned VALUE_W        = 32;
  localparam int unsigned CAP_W          = 11;
  localparam int unsigned APB_ADDR_W     = 3;
  localparam int unsigned APB_DATA_W     = 32;
  localparam int unsigned MAX_DEPTH_DEF  = 1024;
  localparam int unsigned WORD_WIDTH_DEF = 32;

  localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(1024);

  // register index, taken from paddr above the byte offset
  localparam logic [APB_ADDR_W-3:0] REG_CAPACITY = '0;

  typedef enum logic [KIND_W-1:0] {
    KIND_PUSH_FRONT = 3'd0,
    KIND_PUSH_REAR  = 3'd1,
    KIND_POP_FRONT  = 3'd2,
    KIND_POP_REAR   = 3'd3,
    KIND_LOOK       = 3'd4
  } kind_e;

  typedef enum logic {
    ST_IDLE   = 1'b0,
    ST_RESULT = 1'b1
  } state_e;

endpackage

`default_nettype wire

// ===== rtl/bdq_in_if.sv =====
// ----------------------------------------------------------------------------
// bdq_in_if
// operation channel: kind and value with valid/ready
// ----------------------------------------------------------------------------
`default_nettype none

interface bdq_in_if import bdq_pkg::*; ();

  logic                      valid;
  logic                      ready;
  logic [KIND_W-1:0]         kind;
  logic signed [VALUE_W-1:0] value;

  modport source (output valid, output kind, output value, input ready);
  modport sink   (input valid, input kind, input value, output ready);

endinterface

`default_nettype wire

// ===== rtl/bdq_out_if.sv =====
// ----------------------------------------------------------------------------
// bdq_out_if
// result channel: status, end values and flags with valid/ready
// ----------------------------------------------------------------------------
`default_nettype none

interface bdq_out_if import bdq_pkg::*; ();

  logic                      valid;
  logic                      ready;
  logic                      ok;
  logic signed [VALUE_W-1:0] front_value;
  logic signed [VALUE_W-1:0] rear_value;
  logic                      is_empty;
  logic                      is_full;

  modport source (output valid, output ok, output front_value, output rear_value,
                  output is_empty, output is_full, input ready);
  modport sink   (input valid, input ok, input front_value, input rear_value,
                  input is_empty, input is_full, output ready);

endinterface

`default_nettype wire

// ===== rtl/bounded_double_ended_queue_top.sv =====
// result: a word is accepted, a pop issues its memory read at that edge, the read data
//   is back in ST_RESULT and the result word loads into the output register once it is free
// flow: a new operation is taken only in ST_IDLE, after the last result was loaded;
//   the read of the entry memory supplies the new front or rear after a pop
// reset: head, tail and count clear, capacity returns to 1024; the entry memory
//   is not cleared; a pop that empties the queue can read a slot not yet written
// ----------------------------------------------------------------------------
// bounded_double_ended_queue_top
// ring-buffer deque with cached end values and an apb capacity register
// ----------------------------------------------------------------------------
`default_nettype none

`include "bounded_double_ended_queue_top_defines.svh"

module bounded_double_ended_queue_top import bdq_pkg::*; #(
  parameter int unsigned MAX_DEPTH  = MAX_DEPTH_DEF,
  parameter int unsigned WORD_WIDTH = WORD_WIDTH_DEF
) (
  input  wire                   clk_i,
  input  wire                   rst_ni,
  bdq_in_if.sink                in_i,
  bdq_out_if.source             out_o,
  input  wire                   psel,
  input  wire                   penable,
  input  wire                   pwrite,
  input  wire [APB_ADDR_W-1:0]  paddr,
  input  wire [APB_DATA_W-1:0]  pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready
);

  localparam int unsigned AW = $clog2(MAX_DEPTH);
  localparam int unsigned CW = $clog2(MAX_DEPTH + 1);
  localparam int unsigned LW = (CW > CAP_W) ? CW : CAP_W;

  localparam logic [AW-1:0] LAST_SLOT = AW'(MAX_DEPTH - 1);

  function automatic logic [AW-1:0] next_slot(input logic [AW-1:0] i);
    return (i == LAST_SLOT) ? '0 : i + AW'(1);
  endfunction

  function automatic logic [AW-1:0] prev_slot(input logic [AW-1:0] i);
    return (i == '0) ? LAST_SLOT : i - AW'(1);
  endfunction

  // control state
  state_e           state_q, state_d;
  logic [AW-1:0]    head_q, head_d;
  logic [AW-1:0]    tail_q, tail_d;
  logic [CW-1:0]    count_q, count_d;
  logic [CAP_W-1:0] cap_q, cap_d;
  logic             ok_q, ok_d;
  logic             rd_front_q, rd_front_d;
  logic             rd_rear_q, rd_rear_d;
  logic             out_valid_q, out_valid_d;

  // cached end values
  logic signed [WORD_WIDTH-1:0] front_q, front_d;
  logic signed [WORD_WIDTH-1:0] rear_q, rear_d;

  // output word
  logic                      out_ok_q;
  logic signed [VALUE_W-1:0] out_front_q, out_front_d;
  logic signed [VALUE_W-1:0] out_rear_q, out_rear_d;
  logic                      out_empty_q, out_empty_d;
  logic                      out_full_q, out_full_d;
  logic                      load_out;

  // entry memory
  logic [WORD_WIDTH-1:0] entry_mem [MAX_DEPTH];
  logic [WORD_WIDTH-1:0] rd_data_q;
  logic                  mem_we, mem_re;
  logic [AW-1:0]         mem_waddr, mem_raddr;

  logic [LW-1:0]                lim;
  logic [LW-1:0]                cap_ext;
  logic [LW-1:0]                count_ext;
  logic                         is_full_now;
  logic                         in_fire;
  logic signed [WORD_WIDTH-1:0] word;
  logic signed [WORD_WIDTH-1:0] front_cur, rear_cur;
  logic                         cfg_we;

  // capacity zero acts as one, above the depth saturates
  always_comb begin
    cap_ext   = LW'(cap_q);
    count_ext = LW'(count_q);
    if (cap_q == '0) begin
      lim = LW'(1);
    end else if (cap_ext > LW'(MAX_DEPTH)) begin
      lim = LW'(MAX_DEPTH);
    end else begin
      lim = cap_ext;
    end
    is_full_now = (count_ext >= lim);
  end

  assign word      = WORD_WIDTH'(in_i.value);
  assign in_fire   = in_i.valid && in_i.ready;
  assign front_cur = rd_front_q ? $signed(rd_data_q) : front_q;
  assign rear_cur  = rd_rear_q ? $signed(rd_data_q) : rear_q;

  // apb register
  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite
               && (paddr[APB_ADDR_W-1:2] == REG_CAPACITY);
  assign cap_d  = cfg_we ? pwdata[CAP_W-1:0] : cap_q;

  always_comb begin
    if (paddr[APB_ADDR_W-1:2] == REG_CAPACITY) begin
      prdata = APB_DATA_W'(cap_q);
    end else begin
      prdata = '0;
    end
  end

  // next state and outputs
  always_comb begin
    state_d     = state_q;
    head_d      = head_q;
    tail_d      = tail_q;
    count_d     = count_q;
    ok_d        = ok_q;
    rd_front_d  = rd_front_q;
    rd_rear_d   = rd_rear_q;
    front_d     = front_q;
    rear_d      = rear_q;
    mem_we      = 1'b0;
    mem_re      = 1'b0;
    mem_waddr   = head_q;
    mem_raddr   = head_q;
    load_out    = 1'b0;
    in_i.ready  = 1'b0;

    case (state_q)
      ST_IDLE: begin
        in_i.ready = 1'b1;
        if (in_i.valid) begin
          state_d    = ST_RESULT;
          ok_d       = 1'b1;
          rd_front_d = 1'b0;
          rd_rear_d  = 1'b0;
          case (kind_e'(in_i.kind))
            KIND_PUSH_FRONT: begin
              if (is_full_now) begin
                ok_d = 1'b0;
              end else begin
                head_d    = prev_slot(head_q);
                mem_we    = 1'b1;
                mem_waddr = prev_slot(head_q);
                front_d   = word;
                if (count_q == '0) begin
                  rear_d = word;
                end
                count_d = count_q + CW'(1);
              end
            end
            KIND_PUSH_REAR: begin
              if (is_full_now) begin
                ok_d = 1'b0;
              end else begin
                tail_d    = next_slot(tail_q);
                mem_we    = 1'b1;
                mem_waddr = tail_q;
                rear_d    = word;
                if (count_q == '0) begin
                  front_d = word;
                end
                count_d = count_q + CW'(1);
              end
            end
            KIND_POP_FRONT: begin
              if (count_q == '0) begin
                ok_d = 1'b0;
              end else begin
                // new front comes from the memory next cycle
                head_d     = next_slot(head_q);
                mem_re     = 1'b1;
                mem_raddr  = next_slot(head_q);
                rd_front_d = 1'b1;
                count_d    = count_q - CW'(1);
              end
            end
            KIND_POP_REAR: begin
              if (count_q == '0) begin
                ok_d = 1'b0;
              end else begin
                tail_d    = prev_slot(tail_q);
                mem_re    = 1'b1;
                mem_raddr = prev_slot(prev_slot(tail_q));
                rd_rear_d = 1'b1;
                count_d   = count_q - CW'(1);
              end
            end
            default: begin
              // look and unused codes change nothing
            end
          endcase
        end
      end
      ST_RESULT: begin
        if (!out_valid_q || out_o.ready) begin
          load_out   = 1'b1;
          state_d    = ST_IDLE;
          front_d    = front_cur;
          rear_d     = rear_cur;
          rd_front_d = 1'b0;
          rd_rear_d  = 1'b0;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_empty_d = (count_q == '0);
    out_full_d  = is_full_now;
    if (count_q == '0) begin
      out_front_d = '1;
      out_rear_d  = '1;
    end else begin
      out_front_d = VALUE_W'(front_cur);
      out_rear_d  = VALUE_W'(rear_cur);
    end
    if (load_out) begin
      out_valid_d = 1'b1;
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      head_q      <= '0;
      tail_q      <= '0;
      count_q     <= '0;
      cap_q       <= CAP_RESET;
      ok_q        <= 1'b0;
      rd_front_q  <= 1'b0;
      rd_rear_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      head_q      <= head_d;
      tail_q      <= tail_d;
      count_q     <= count_d;
      cap_q       <= cap_d;
      ok_q        <= ok_d;
      rd_front_q  <= rd_front_d;
      rd_rear_q   <= rd_rear_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    front_q <= front_d;
    rear_q  <= rear_d;
    if (load_out) begin
      out_ok_q    <= ok_q;
      out_front_q <= out_front_d;
      out_rear_q  <= out_rear_d;
      out_empty_q <= out_empty_d;
      out_full_q  <= out_full_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      entry_mem[mem_waddr] <= word;
    end
    if (mem_re) begin
      rd_data_q <= entry_mem[mem_raddr];
    end
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.ok          = out_ok_q;
  assign out_o.front_value = out_front_q;
  assign out_o.rear_value  = out_rear_q;
  assign out_o.is_empty    = out_empty_q;
  assign out_o.is_full     = out_full_q;

  `BDQ_NEVER(a_count_range, (CW'(MAX_DEPTH) < count_q), "entry count above depth")
  `BDQ_ASSERT(a_empty_ptrs, (count_q == '0) |-> (head_q == tail_q), "empty but head != tail")
  `BDQ_ASSERT(a_fire_result, in_fire |=> (state_q == ST_RESULT), "accepted word lost")
  `BDQ_ASSERT(a_load_idle, load_out |=> (state_q == ST_IDLE) && out_valid_q, "result not held")

endmodule

`default_nettype wire
